### hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the stable priority queue
// Entry and per-cycle control types seen by every cell, request and
// status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int TAG_W  = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 6;
    localparam int STAT_W = 2;

    // request kinds (s_tuser)
    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    // result status codes (m_tuser)
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } spq_entry_t;

    // broadcast to all cells each cycle
    typedef struct packed {
        logic       push;   // insert entry in sorted place
        logic       pop;    // shift whole row toward the head
        spq_entry_t entry;  // entry being pushed
    } spq_ctrl_t;

endpackage
`default_nettype wire

### hdl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry row
// Keeps its entry, takes the pushed entry or its upstream neighbor's on an
// insert, or its downstream neighbor's on a pop.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int COUNT_W    = 6,
    parameter int CELL_INDEX = 0
) (
    input  wire                 aclk,
    input  spq_pkg::spq_ctrl_t  ctrl,
    input  wire [COUNT_W-1:0]   count,
    input  spq_pkg::spq_entry_t prev_entry,
    input  wire                 prev_keep,
    input  spq_pkg::spq_entry_t next_entry,
    output logic                keep,
    output spq_pkg::spq_entry_t entry
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;
    logic                occupied;

    always_comb begin
        occupied = (COUNT_W'(CELL_INDEX) < count);
        // equal priority stays ahead: arrival order among ties
        keep     = occupied && (entry_reg.prio >= ctrl.entry.prio);
        entry_next = entry_reg;
        if (ctrl.pop) begin
            entry_next = next_entry;
        end else if (ctrl.push && !keep) begin
            entry_next = prev_keep ? ctrl.entry : prev_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

### hdl/stable_priority_queue_unit.sv
// A result is registered and appears on m_* in the cycle after its request is accepted.
// Throughput: one request per cycle; every cell compares and shifts in the
// same cycle, and a new request is taken in the cycle that the waiting result
// drains. A stalled result holds s_tready low. Reset (aresetn low, synchronous)
// empties the queue and drops a pending result; the entry cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_unit: priority task queue, FIFO among equal priority
// Row of QUEUE_SLOTS-1 cells kept sorted by priority (descending) and by
// arrival among ties. Push inserts in place, pop takes the head.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit #(
    parameter int QUEUE_SLOTS = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    // request channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [15:0] task_tag, [23:16] task_priority
    input  wire         s_tuser,   // [0] action: 0 push, 1 pop
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [15:0] out_tag, [23:16] out_priority,
                                   // [29:24] occupancy, [31:30] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CAPACITY = QUEUE_SLOTS - 1;
    localparam int COUNT_W  = $clog2(QUEUE_SLOTS);

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic                s_accept;
    logic                is_pop;
    logic                full;
    logic                empty;
    spq_pkg::spq_entry_t req_entry;
    spq_pkg::spq_ctrl_t  ctrl;

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    // output register
    logic                               out_valid_reg;
    logic [spq_pkg::STAT_W-1:0]         out_status_reg;
    logic [spq_pkg::STAT_W-1:0]         out_status_next;
    spq_pkg::spq_entry_t                out_entry_reg;
    spq_pkg::spq_entry_t                out_entry_next;
    logic [spq_pkg::OCC_W-1:0]          out_occ_reg;

    // cell row
    spq_pkg::spq_entry_t entry_bus      [CAPACITY];
    spq_pkg::spq_entry_t prev_entry_bus [CAPACITY];
    spq_pkg::spq_entry_t next_entry_bus [CAPACITY];
    logic                keep_bus       [CAPACITY];
    logic                prev_keep_bus  [CAPACITY];

    // output slot is free when empty or being drained this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign is_pop         = (s_tuser == spq_pkg::ACTION_POP);
    assign full           = (count_reg == COUNT_W'(CAPACITY));
    assign empty          = (count_reg == '0);
    assign req_entry.tag  = s_tdata[15:0];
    assign req_entry.prio = s_tdata[23:16];

    always_comb begin
        ctrl.entry = req_entry;
        ctrl.push  = s_accept && !is_pop && !full;
        ctrl.pop   = s_accept && is_pop && !empty;

        count_next = count_reg;
        if (ctrl.push) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - COUNT_W'(1);
        end

        // result fields; tag and priority only on a served pop
        out_status_next = spq_pkg::STATUS_OK;
        out_entry_next  = '0;
        if (is_pop) begin
            if (empty) begin
                out_status_next = spq_pkg::STATUS_EMPTY;
            end else begin
                out_entry_next = entry_bus[0];   // head is the best entry
            end
        end else if (full) begin
            out_status_next = spq_pkg::STATUS_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_occ_reg    <= spq_pkg::OCC_W'(count_next);  // count modulo 64
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_occ_reg, out_entry_reg.prio, out_entry_reg.tag};

    // ------------------------------------------------------------------
    // sorted cell row: cell 0 is the head
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prev_keep_bus[i]  = 1'b1;
            assign prev_entry_bus[i] = req_entry;
        end else begin : g_body
            assign prev_keep_bus[i]  = keep_bus[i-1];
            assign prev_entry_bus[i] = entry_bus[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            // past the tail: content beyond count is never read
            assign next_entry_bus[i] = req_entry;
        end else begin : g_mid
            assign next_entry_bus[i] = entry_bus[i+1];
        end

        spq_cell #(
            .COUNT_W    (COUNT_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .prev_entry (prev_entry_bus[i]),
            .prev_keep  (prev_keep_bus[i]),
            .next_entry (next_entry_bus[i]),
            .keep       (keep_bus[i]),
            .entry      (entry_bus[i])
        );
    end

`ifndef NO_ASSERTIONS
    // count stays within capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a served pop reports ok on the next cycle
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_pop && !empty |=> m_tvalid && m_tuser == spq_pkg::STATUS_OK)
        else $error("served pop did not report ok");

    // a rejected push leaves the queue alone
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !is_pop && full |=> $stable(count_reg))
        else $error("rejected push changed the count");

    // new head never outranks the entry just popped
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_pop && count_reg > COUNT_W'(1)
        |=> entry_bus[0].prio <= m_tdata[23:16])
        else $error("row not sorted after pop");
`endif

endmodule
`default_nettype wire
